>>> rtl/pwm_period_duty_to_settings_macros.svh
// Assertion helpers used by the checker file.
`ifndef PWM_PERIOD_DUTY_TO_SETTINGS_MACROS_SVH
`define PWM_PERIOD_DUTY_TO_SETTINGS_MACROS_SVH

// Generic clocked assertion with async active-low reset disable.
`define PWMPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pwmpd assertion failed");

// Same, on the usual clk_i / rst_ni pair.
`define PWMPD_ASSERT_CLK(lbl, prop) `PWMPD_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/pwmpd_pkg.sv
`default_nettype none
package pwmpd_pkg;

  localparam int BASE_W    = 38;          // 256e9 / 1 Hz fits in 38 bits
  localparam int PER_W     = 45;          // base shifted by up to 7
  localparam int NUM_W     = 46;          // duty*256 + period/2
  localparam int PROD_W    = PER_W + 8;
  localparam int HZ_W      = 30;
  localparam int CFG_IDX_W = 8;
  localparam int CNT_W     = 6;

  localparam logic [BASE_W-1:0] NS_STEPS = 38'd256000000000;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HZ  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_HZ   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_OFF = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_DIV1  = 8'd3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RATE_ZERO   = 2'd1,
    ST_UNREACHABLE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BC_SLOW = 2'd0,
    BC_SYS  = 2'd1,
    BC_DONE = 2'd2
  } base_state_e;

  typedef struct packed {
    status_e    status;
    logic       use_sys;
    logic [2:0] exp;
    logic       pol;
    logic       en;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [PER_W-1:0] period;
    logic [NUM_W-1:0] rem;
    logic [7:0]       q;
    logic             sat;
  } div_beat_t;

endpackage
`default_nettype wire

>>> rtl/pwmpd_if.sv
`default_nettype none
interface pwmpd_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] requested_period_ns;
  logic [31:0] requested_duty_ns;
  logic        polarity_normal;
  logic        enable_request;

  modport source (output valid, requested_period_ns, requested_duty_ns,
                  polarity_normal, enable_request, input ready);
  modport sink   (input valid, requested_period_ns, requested_duty_ns,
                  polarity_normal, enable_request, output ready);
endinterface

interface pwmpd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        use_system_clock;
  logic [2:0]  prescale_exponent;
  logic [7:0]  compare_value;
  logic        polarity_bit;
  logic        enable_out;
  logic [43:0] actual_period_ns;
  logic [43:0] actual_duty_ns;

  modport source (output valid, status, use_system_clock, prescale_exponent,
                  compare_value, polarity_bit, enable_out, actual_period_ns,
                  actual_duty_ns, input ready);
  modport sink   (input valid, status, use_system_clock, prescale_exponent,
                  compare_value, polarity_bit, enable_out, actual_period_ns,
                  actual_duty_ns, output ready);
endinterface
`default_nettype wire

>>> rtl/pwmpd_base_calc.sv
`default_nettype none
// Radix-2 restoring divider: slow base, then rounded system base.
module pwmpd_base_calc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          restart_i,
  input  wire logic [pwmpd_pkg::HZ_W-1:0]    slow_hz_i,
  input  wire logic [pwmpd_pkg::HZ_W-1:0]    sys_hz_i,
  output logic [pwmpd_pkg::BASE_W-1:0]       slow_base_o,
  output logic [pwmpd_pkg::BASE_W-1:0]       sys_base_o,
  output logic                               ready_o
);
  import pwmpd_pkg::*;

  base_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [HZ_W-1:0]   rem_q, rem_next;
  logic [BASE_W-1:0] quo_q, quo_next;
  logic [BASE_W-1:0] slow_base_q, sys_base_q;
  logic [BASE_W-1:0] dividend, src_quo;
  logic [HZ_W-1:0]   divisor, src_rem;
  logic [HZ_W:0]     shifted;
  logic              fits, last, busy;

  always_comb begin
    divisor  = (state_q == BC_SYS) ? sys_hz_i : slow_hz_i;
    dividend = (state_q == BC_SYS) ? NS_STEPS + BASE_W'(sys_hz_i >> 1) : NS_STEPS;
    src_quo  = (cnt_q == '0) ? dividend : quo_q;
    src_rem  = (cnt_q == '0) ? '0 : rem_q;
    shifted  = {src_rem, src_quo[BASE_W-1]};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? HZ_W'(shifted - {1'b0, divisor}) : shifted[HZ_W-1:0];
    quo_next = {src_quo[BASE_W-2:0], fits};
    last     = cnt_q == CNT_W'(BASE_W - 1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BC_SLOW: if (last) state_d = BC_SYS;
      BC_SYS:  if (last) state_d = BC_DONE;
      BC_DONE: state_d = BC_DONE;
      default: state_d = BC_SLOW;
    endcase
    if (restart_i) state_d = BC_SLOW;
  end

  always_comb begin
    busy    = state_q != BC_DONE;
    ready_o = state_q == BC_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BC_SLOW;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i || last) cnt_q <= '0;
      else if (busy) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (state_q == BC_SLOW && last) slow_base_q <= quo_next;
    if (state_q == BC_SYS && last)  sys_base_q  <= quo_next;
  end

  assign slow_base_o = slow_base_q;
  assign sys_base_o  = sys_base_q;
endmodule
`default_nettype wire

>>> rtl/pwmpd_div_stage.sv
`default_nettype none
// One quotient bit of the compare-value divide, registered.
module pwmpd_div_stage #(
  parameter int BIT = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire logic                  valid_i,
  input  wire pwmpd_pkg::div_beat_t  beat_i,
  output logic                       valid_o,
  output pwmpd_pkg::div_beat_t       beat_o
);
  import pwmpd_pkg::*;

  logic              valid_q;
  div_beat_t         beat_q, beat_d;
  logic [PROD_W-1:0] step, rem_w;
  logic              take;

  always_comb begin
    step   = PROD_W'(beat_i.period) << BIT;
    rem_w  = PROD_W'(beat_i.rem);
    take   = !beat_i.sat && (rem_w >= step);
    beat_d = beat_i;
    if (take) begin
      beat_d.rem = NUM_W'(rem_w - step);
      beat_d.q   = beat_i.q | (8'd1 << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (adv_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule
`default_nettype wire

>>> rtl/pwm_period_duty_to_settings.sv
`default_nettype none
// Channel   Dir  Payload
// req_i     in   requested_period_ns, requested_duty_ns, polarity_normal, enable_request
// res_o     out  status, use_system_clock, prescale_exponent, compare_value,
//                polarity_bit, enable_out, actual_period_ns, actual_duty_ns
// cfg_*     in   write enable, register index, 30-bit data
//
// One beat per cycle while res_o does not stall; the pipe has 4 setup stages,
// 8 one-bit divide stages, multiply and round.
// After reset and after every config write the base periods are rebuilt by a
// 38-step serial divider, twice (slow then system): req_i.ready stays low
// until both are done, and also during a write itself. Config writes are
// taken at any time.
// A stall on res_o freezes the whole pipe; nothing is dropped or repeated.
module pwm_period_duty_to_settings #(
  parameter int MAX_PRESCALE_EXP = 6
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  pwmpd_req_if.sink                              req_i,
  pwmpd_res_if.source                            res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [pwmpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pwmpd_pkg::HZ_W-1:0]        cfg_data_i
);
  import pwmpd_pkg::*;

  localparam int NDIV = 8;

  // config registers
  logic [HZ_W-1:0] slow_hz_q, sys_hz_q;
  logic            slow_off_q, no_div1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_hz_q  <= 30'd32768;
      sys_hz_q   <= 30'd133000000;
      slow_off_q <= 1'b0;
      no_div1_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SLOW_HZ:  slow_hz_q  <= cfg_data_i;
        CFG_SYS_HZ:   sys_hz_q   <= cfg_data_i;
        CFG_SLOW_OFF: slow_off_q <= cfg_data_i[0];
        CFG_NO_DIV1:  no_div1_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // base periods, rebuilt on every config write
  logic [BASE_W-1:0] slow_base, sys_base;
  logic              base_ready;

  pwmpd_base_calc u_base (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .slow_hz_i   (slow_hz_q),
    .sys_hz_i    (sys_hz_q),
    .slow_base_o (slow_base),
    .sys_base_o  (sys_base),
    .ready_o     (base_ready)
  );

  // whole pipe advances together
  logic o_v_q, adv, accept;
  assign adv         = !o_v_q || res_o.ready;
  assign req_i.ready = adv && base_ready && !cfg_we_i;
  assign accept      = req_i.valid && req_i.ready;

  // stage A: clock choice
  logic              a_v_q;
  ctl_t              a_ctl_q, a_ctl_d;
  logic [BASE_W-1:0] a_base_q, a_base_d;
  logic [31:0]       a_req_q, a_duty_q;
  logic              use_sys;

  always_comb begin
    use_sys = slow_off_q || (slow_base > BASE_W'(req_i.requested_period_ns));
    a_ctl_d = '{status: ST_OK, use_sys: use_sys, exp: 3'd0,
                pol: req_i.polarity_normal, en: req_i.enable_request};
    if (!slow_off_q && slow_hz_q == '0) a_ctl_d.status = ST_RATE_ZERO;
    else if (use_sys && sys_hz_q == '0) a_ctl_d.status = ST_RATE_ZERO;
    a_base_d = use_sys ? sys_base : slow_base;
  end

  // stage B: smallest prescale that covers the request
  logic              b_v_q;
  ctl_t              b_ctl_q, b_ctl_d;
  logic [BASE_W-1:0] b_base_q;
  logic [31:0]       b_duty_q;
  logic              found;
  logic [2:0]        exp_sel;

  always_comb begin
    found   = 1'b0;
    exp_sel = 3'd0;
    for (int e = MAX_PRESCALE_EXP; e >= 0; e--) begin
      if (((PER_W'(a_base_q) << e) >= PER_W'(a_req_q)) && !(e == 0 && no_div1_q)) begin
        found   = 1'b1;
        exp_sel = 3'(e);
      end
    end
    b_ctl_d     = a_ctl_q;
    b_ctl_d.exp = exp_sel;
    if (a_ctl_q.status == ST_OK && !found) b_ctl_d.status = ST_UNREACHABLE;
  end

  // stage C: period and rounded dividend
  logic             c_v_q;
  ctl_t             c_ctl_q;
  logic [PER_W-1:0] c_period_q, c_period_d;
  logic [NUM_W-1:0] c_num_q, c_num_d;

  always_comb begin
    c_period_d = PER_W'(b_base_q) << b_ctl_q.exp;
    c_num_d    = (NUM_W'(b_duty_q) << 8) + NUM_W'(c_period_d >> 1);
  end

  // stage D: saturation test, divide setup
  logic              d_v_q;
  div_beat_t         d_beat_q, d_beat_d;
  logic              sat;

  always_comb begin
    sat      = PROD_W'(c_num_q) >= (PROD_W'(c_period_q) << 8);
    d_beat_d = '{ctl: c_ctl_q, period: c_period_q, rem: c_num_q,
                 q: sat ? 8'hFF : 8'h00, sat: sat};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= accept;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ctl_q    <= a_ctl_d;
      a_base_q   <= a_base_d;
      a_req_q    <= req_i.requested_period_ns;
      a_duty_q   <= req_i.requested_duty_ns;
      b_ctl_q    <= b_ctl_d;
      b_base_q   <= a_base_q;
      b_duty_q   <= a_duty_q;
      c_ctl_q    <= b_ctl_q;
      c_period_q <= c_period_d;
      c_num_q    <= c_num_d;
      d_beat_q   <= d_beat_d;
    end
  end

  // divide: one quotient bit per stage, MSB first
  logic      dv   [NDIV+1];
  div_beat_t dbeat[NDIV+1];
  assign dv[0]    = d_v_q;
  assign dbeat[0] = d_beat_q;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    pwmpd_div_stage #(.BIT(NDIV - 1 - k)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv[k]),
      .beat_i  (dbeat[k]),
      .valid_o (dv[k+1]),
      .beat_o  (dbeat[k+1])
    );
  end

  // stage M: compare * period
  logic              m_v_q;
  ctl_t              m_ctl_q;
  logic [7:0]        m_q_q;
  logic [PER_W-1:0]  m_period_q;
  logic [PROD_W-1:0] m_prod_q;

  // stage O: round, output register
  ctl_t              o_ctl_q, o_ctl_d;
  logic [7:0]        o_cmp_q;
  logic [43:0]       o_period_q, o_duty_q;
  logic [PROD_W-1:0] duty_sum;
  logic              o_err;

  assign duty_sum = m_prod_q + PROD_W'(128);
  assign o_err    = m_ctl_q.status != ST_OK;

  // error beats carry nothing but the status
  always_comb begin
    o_ctl_d = m_ctl_q;
    if (o_err) begin
      o_ctl_d.use_sys = 1'b0;
      o_ctl_d.exp     = 3'd0;
      o_ctl_d.pol     = 1'b0;
      o_ctl_d.en      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      m_v_q <= dv[NDIV];
      o_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_ctl_q    <= dbeat[NDIV].ctl;
      m_q_q      <= dbeat[NDIV].q;
      m_period_q <= dbeat[NDIV].period;
      m_prod_q   <= PROD_W'(dbeat[NDIV].q) * PROD_W'(dbeat[NDIV].period);
      o_ctl_q    <= o_ctl_d;
      o_cmp_q    <= o_err ? 8'd0 : m_q_q;
      o_period_q <= o_err ? 44'd0 : m_period_q[43:0];
      o_duty_q   <= o_err ? 44'd0 : duty_sum[51:8];
    end
  end

  assign res_o.valid             = o_v_q;
  assign res_o.status            = o_ctl_q.status;
  assign res_o.use_system_clock  = o_ctl_q.use_sys;
  assign res_o.prescale_exponent = o_ctl_q.exp;
  assign res_o.compare_value     = o_cmp_q;
  assign res_o.polarity_bit      = o_ctl_q.pol;
  assign res_o.enable_out        = o_ctl_q.en;
  assign res_o.actual_period_ns  = o_period_q;
  assign res_o.actual_duty_ns    = o_duty_q;
endmodule
`default_nettype wire

>>> rtl/pwmpd_checker.sv
`default_nettype none
`include "pwm_period_duty_to_settings_macros.svh"
module pwmpd_checker #(
  parameter int MAX_PRESCALE_EXP = 6
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [1:0]  status_i,
  input wire logic        use_sys_i,
  input wire logic [2:0]  exp_i,
  input wire logic [7:0]  cmp_i,
  input wire logic [43:0] period_i,
  input wire logic [43:0] duty_i
);
  import pwmpd_pkg::*;

  // error results carry nothing but the status
  `PWMPD_ASSERT_CLK(a_err_zero, valid_i && status_i != ST_OK |-> use_sys_i == 1'b0 && exp_i == 3'd0 && cmp_i == 8'd0 && period_i == '0 && duty_i == '0)
  // prescale stays inside the allowed range
  `PWMPD_ASSERT_CLK(a_exp_range, valid_i && status_i == ST_OK |-> exp_i <= 3'(MAX_PRESCALE_EXP))
  // no undefined status code
  `PWMPD_ASSERT_CLK(a_status_code, valid_i |-> status_i != 2'd3)
  // stalled beat holds
  `PWMPD_ASSERT_CLK(a_hold, valid_i && !ready_i |=> valid_i && $stable(cmp_i) && $stable(duty_i))
endmodule

bind pwm_period_duty_to_settings pwmpd_checker #(
  .MAX_PRESCALE_EXP(MAX_PRESCALE_EXP)
) u_pwmpd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (res_o.valid),
  .ready_i   (res_o.ready),
  .status_i  (res_o.status),
  .use_sys_i (res_o.use_system_clock),
  .exp_i     (res_o.prescale_exponent),
  .cmp_i     (res_o.compare_value),
  .period_i  (res_o.actual_period_ns),
  .duty_i    (res_o.actual_duty_ns)
);
`default_nettype wire

>>> verif/pwm_period_duty_to_settings_tb.sv
module pwm_period_duty_to_settings_tb;
  import pwmpd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [HZ_W-1:0] cfg_data_i = '0;

  pwmpd_req_if req();
  pwmpd_res_if res();

  pwm_period_duty_to_settings dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req.sink), .res_o(res.source),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Expected result beat, same field widths as the result channel.
  typedef struct packed {
    logic [1:0]  status;
    logic        use_sys;
    logic [2:0]  exp;
    logic [7:0]  cmp;
    logic        pol;
    logic        en;
    logic [43:0] period;
    logic [43:0] duty;
  } setting_t;

  setting_t settings_q[$];
  int errors = 0;

  // Local copy of the configuration registers.
  logic [29:0] slow_hz;
  logic [29:0] sys_hz;
  logic        slow_off;
  logic        no_div1;

  // Receiver control: per-beat random stall, optional long hold.
  logic hold_res = 1'b0;
  logic idle_res = 1'b0;  // no stall at all in some stretches

  initial begin
    req.valid = 1'b0;
    req.requested_period_ns = '0;
    req.requested_duty_ns = '0;
    req.polarity_normal = 1'b0;
    req.enable_request = 1'b0;
    res.ready = 1'b0;
  end

  // Compute the register settings for one request.
  function automatic setting_t compute_settings(logic [31:0] rp, logic [31:0] rd,
                                                logic pol, logic en);
    setting_t s;
    logic [63:0] base;
    logic [63:0] per;
    logic [63:0] c;
    logic use_sys;
    bit found;
    int e;
    s = '0;
    base = '0;
    use_sys = 1'b0;
    found = 0;
    if (!slow_off) begin
      if (slow_hz == 0) begin
        s.status = ST_RATE_ZERO;
        return s;
      end
      base = 64'd256000000000 / slow_hz;
    end
    if (slow_off || base > {32'd0, rp}) begin
      if (sys_hz == 0) begin
        s.status = ST_RATE_ZERO;
        return s;
      end
      use_sys = 1'b1;
      base = (64'd256000000000 + sys_hz / 2) / sys_hz;
    end
    for (e = 0; e <= 6; e++) begin
      if (e == 0 && no_div1) continue;
      if ((base << e) >= {32'd0, rp}) begin
        found = 1;
        break;
      end
    end
    if (!found) begin
      s.status = ST_UNREACHABLE;
      return s;
    end
    per = base << e;
    if (per == 0) c = 64'd255;
    else begin
      c = ({32'd0, rd} * 256 + per / 2) / per;
      if (c > 255) c = 64'd255;
    end
    s.status = ST_OK;
    s.use_sys = use_sys;
    s.exp = e[2:0];
    s.cmp = c[7:0];
    s.pol = pol;
    s.en = en;
    s.period = per[43:0];
    s.duty = 44'((c * per + 128) / 256);
    return s;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [29:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SLOW_HZ:  slow_hz = val;
      CFG_SYS_HZ:   sys_hz = val;
      CFG_SLOW_OFF: slow_off = val[0];
      CFG_NO_DIV1:  no_div1 = val[0];
      default: ;
    endcase
  endtask

  // Send one request beat; gap drawn per beat unless told otherwise.
  // Valid stays up after the beat so a gap of zero gives back-to-back beats;
  // drain() drops it.
  task automatic send_request(logic [31:0] rp, logic [31:0] rd, logic pol, logic en,
                              bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.requested_period_ns <= rp;
    req.requested_duty_ns <= rd;
    req.polarity_normal <= pol;
    req.enable_request <= en;
    do @(posedge clk_i); while (!req.ready);
    settings_q.push_back(compute_settings(rp, rd, pol, en));
  endtask

  // Wait until every expected beat has come back, plus pipeline latency.
  task automatic drain();
    req.valid <= 1'b0;
    while (settings_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Receiver: random stall per beat, or always ready in quiet stretches.
  initial begin : res_ready_drv
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    res.ready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!res.valid);
      stall = idle_res ? 0 : $urandom_range(0, 19);
      if (stall != 0 || hold_res) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_res) @(posedge clk_i);
        res.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    setting_t exp_s;
    setting_t got;
    if (rst_ni && res.valid && res.ready) begin
      got = {res.status, res.use_system_clock, res.prescale_exponent,
             res.compare_value, res.polarity_bit, res.enable_out,
             res.actual_period_ns, res.actual_duty_ns};
      if (settings_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat %h", $time, got);
      end else begin
        exp_s = settings_q.pop_front();
        if (got !== exp_s) begin
          errors++;
          $display("%0t mismatch exp st=%0d sys=%0d e=%0d c=%0d p=%0d en=%0d per=%0d d=%0d",
                   $time, exp_s.status, exp_s.use_sys, exp_s.exp, exp_s.cmp, exp_s.pol,
                   exp_s.en, exp_s.period, exp_s.duty);
          $display("%0t          got st=%0d sys=%0d e=%0d c=%0d p=%0d en=%0d per=%0d d=%0d",
                   $time, got.status, got.use_sys, got.exp, got.cmp, got.pol,
                   got.en, got.period, got.duty);
        end
      end
    end
  end

  function automatic logic [31:0] rand_period();
    // Mix full-range values with ones near realistic base periods.
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(0, 200000000);
      default: return $urandom_range(0, 2000000);
    endcase
  endfunction

  task automatic random_requests(int n);
    logic [31:0] rp;
    logic [31:0] rd;
    for (int i = 0; i < n; i++) begin
      rp = rand_period();
      rd = $urandom_range(0, 1) ? $urandom() : 32'($urandom() % (rp + 33'd1));
      send_request(rp, rd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Edges of the request fields on the reset configuration.
  task automatic test_directed();
    send_request(32'd0, 32'd0, 1'b0, 1'b0);
    send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
    send_request(32'hFFFFFFFF, 32'd0, 1'b1, 1'b0);
    send_request(32'd7812500, 32'd3906250, 1'b1, 1'b1);   // slow base exactly
    send_request(32'd7812499, 32'd1000, 1'b0, 1'b1);      // just below slow base
    send_request(32'd1925, 32'd962, 1'b1, 1'b1);          // system base
    send_request(32'd1926, 32'd1926, 1'b1, 1'b0);
    send_request(32'd123200, 32'd50000, 1'b0, 1'b1);      // system max exactly
    send_request(32'd500000000, 32'd600000000, 1'b1, 1'b1); // duty over period
    drain();
  endtask

  // Error statuses and errata settings.
  task automatic test_errata_and_errors();
    write_reg(CFG_SLOW_HZ, 30'd0);                         // slow rate zero
    drain();
    send_request(32'd1000, 32'd500, 1'b1, 1'b1);
    drain();
    write_reg(CFG_SLOW_OFF, 30'd1);
    write_reg(CFG_SYS_HZ, 30'd0);                          // system rate zero
    drain();
    send_request(32'd1000, 32'd500, 1'b1, 1'b1);
    drain();
    write_reg(CFG_SYS_HZ, 30'd1000000000);                 // fastest system clock
    write_reg(CFG_NO_DIV1, 30'd1);
    drain();
    send_request(32'd0, 32'd5, 1'b1, 1'b1);
    send_request(32'd256, 32'd128, 1'b0, 1'b1);
    send_request(32'd512, 32'd128, 1'b1, 1'b0);
    send_request(32'd16385, 32'd1, 1'b1, 1'b1);            // unreachable
    drain();
    write_reg(CFG_SLOW_OFF, 30'd0);
    write_reg(CFG_SLOW_HZ, 30'd1);                         // slowest slow clock
    write_reg(CFG_NO_DIV1, 30'd0);
    drain();
    send_request(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
    send_request(32'd1000, 32'd10, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 8; phase++) begin
      idle_res = (phase == 3);
      write_reg(CFG_SLOW_HZ, $urandom_range(0, 7) == 0 ? 30'd0 :
                30'($urandom_range(0, 1) ? $urandom_range(1, 1000000) :
                    $urandom_range(1, 1000000000)));
      write_reg(CFG_SYS_HZ, $urandom_range(0, 7) == 0 ? 30'd0 :
                30'($urandom_range(1, 1000000000)));
      write_reg(CFG_SLOW_OFF, 30'($urandom_range(0, 1)));
      write_reg(CFG_NO_DIV1, 30'($urandom_range(0, 1)));
      drain();
      random_requests(95);
      drain();
    end
    idle_res = 1'b0;
  endtask

  // Long receiver hold while the sender keeps pushing back-to-back.
  task automatic test_backpressure();
    write_reg(CFG_SLOW_HZ, 30'd32768);
    write_reg(CFG_SYS_HZ, 30'd133000000);
    write_reg(CFG_SLOW_OFF, 30'd0);
    write_reg(CFG_NO_DIV1, 30'd0);
    drain();
    fork
      begin
        hold_res = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_res = 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++)
      send_request(rand_period(), $urandom(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1);
    drain();
  endtask

  initial begin
    slow_hz = 30'd32768;
    sys_hz = 30'd133000000;
    slow_off = 1'b0;
    no_div1 = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_errata_and_errors();
    test_backpressure();
    test_random_configs();
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
